>>> design/mandelbrot_escape_pixel_macros.svh
// Assertion macros for the Mandelbrot escape-time pixel checker.
// Expects signals clk and arst_n in the scope of use; no other dependencies.
`ifndef MANDELBROT_ESCAPE_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_MACROS_SVH

// condition in one cycle implies the consequence in that same cycle
`define MEP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mep assertion failed");

// condition in one cycle implies the consequence in the next cycle
`define MEP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mep assertion failed");

`endif

>>> design/mep_pkg.sv
// Shared widths, constants and types of the Mandelbrot escape-time pixel.
// No dependencies; used by every other file of the block but the macro header.
`timescale 1ns / 1ps

package mep_pkg;

	localparam int COORD_W         = 32;
	localparam int COORD_FRAC_BITS = 28;
	localparam int MAX_ITER_LIMIT  = 256;
	localparam int CNT_W           = 9;
	localparam int COLOR_W         = 8;

	// a z that has not escaped needs FRAC+2 bits; c itself needs COORD_W
	localparam int Z_W = (COORD_FRAC_BITS + 2 > COORD_W) ? COORD_FRAC_BITS + 2 : COORD_W;
	localparam int P_W = 2 * Z_W;   // full product
	localparam int S_W = P_W + 1;   // sum or difference of two products
	localparam int N_W = P_W + 2;   // next z before the escape test

	localparam logic [CNT_W-1:0]   MAX_ITER_RESET = CNT_W'(256);
	localparam logic [CNT_W-1:0]   ITER_CAP       = CNT_W'(MAX_ITER_LIMIT);
	localparam logic [COLOR_W-1:0] BLUE_BASE      = COLOR_W'(64);

	// 4.0 in the squared scale, 2.0 in the coordinate scale
	localparam logic signed [S_W-1:0] ESC_SQ_LIMIT  = S_W'(1) << (2 * COORD_FRAC_BITS + 2);
	localparam logic signed [N_W-1:0] ESC_MAG_LIMIT = N_W'(1) << (COORD_FRAC_BITS + 1);

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] count;
		logic             in_set;
	} iter_res_t;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} shade_t;

endpackage

>>> design/mep_ifs.sv
// Valid/ready channel interfaces: point in, escape result out.
// Depends on mep_pkg for field widths.
`timescale 1ns / 1ps

interface mep_pt_if;
	logic                                valid;
	logic                                ready;
	logic signed [mep_pkg::COORD_W-1:0]  c_re;
	logic signed [mep_pkg::COORD_W-1:0]  c_im;

	modport source (output valid, output c_re, output c_im, input ready);
	modport sink   (input valid, input c_re, input c_im, output ready);
endinterface

interface mep_res_if;
	logic                          valid;
	logic                          ready;
	logic [mep_pkg::CNT_W-1:0]     iter_count;
	logic                          inside_res;
	logic [mep_pkg::COLOR_W-1:0]   blue;
	logic [mep_pkg::COLOR_W-1:0]   green;
	logic [mep_pkg::COLOR_W-1:0]   red;

	modport source (output valid, output iter_count, output inside_res,
		output blue, output green, output red, input ready);
	modport sink   (input valid, input iter_count, input inside_res,
		input blue, input green, input red, output ready);
endinterface

>>> design/mep_mul.sv
// Shared signed multiplier with a registered full-width product.
// Depends on mep_pkg.
`timescale 1ns / 1ps

module mep_mul (
	input  logic                             clk,
	input  logic signed [mep_pkg::Z_W-1:0]   a,
	input  logic signed [mep_pkg::Z_W-1:0]   b,
	output logic signed [mep_pkg::P_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

>>> design/mep_shade.sv
// Colour map from escape count: black inside, else blue/green/red ramps.
// Depends on mep_pkg.
`timescale 1ns / 1ps

module mep_shade (
	input  mep_pkg::iter_res_t res,
	output mep_pkg::shade_t    shade
);

	localparam int CW = mep_pkg::COLOR_W;

	logic [mep_pkg::CNT_W-1:0] half;

	assign half = res.count >> 1;

	always_comb begin
		if (res.in_set) begin
			shade = '0;
		end else begin
			shade.blue  = CW'(mep_pkg::BLUE_BASE + CW'(half));
			shade.green = CW'(half);
			shade.red   = CW'(res.count);
		end
	end

endmodule

>>> design/mep_iter.sv
// Escape-time sequencer: steps z = z*z + c on the shared multiplier.
// Depends on mep_pkg and mep_mul.
`timescale 1ns / 1ps

module mep_iter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [mep_pkg::COORD_W-1:0]    c_re,
	input  logic signed [mep_pkg::COORD_W-1:0]    c_im,
	input  logic [mep_pkg::CNT_W-1:0]             limit,
	input  logic                                  ack,
	output logic                                  idle,
	output mep_pkg::iter_res_t                    res
);

	localparam int ZW = mep_pkg::Z_W;
	localparam int SW = mep_pkg::S_W;
	localparam int NW = mep_pkg::N_W;
	localparam int F  = mep_pkg::COORD_FRAC_BITS;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RR   = 6'b000010,
		ST_II   = 6'b000100,
		ST_RI   = 6'b001000,
		ST_UPD  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic signed [ZW-1:0]                zr_q, zi_q, op_a, op_b;
	logic signed [mep_pkg::COORD_W-1:0]  cr_q, ci_q;
	logic signed [mep_pkg::P_W-1:0]      prod_q, rr_q;
	logic signed [SW-1:0]                diff_q, diff, sum_sq;
	logic signed [NW-1:0]                nr, ni;
	logic [mep_pkg::CNT_W-1:0]           n_q, n_inc;
	logic                                first_q, inside_q;
	logic                                esc_sq, esc_mag;

	mep_mul u_mul (
		.clk    (clk),
		.a      (op_a),
		.b      (op_b),
		.prod_q (prod_q)
	);

	always_comb begin
		case (state_q)
			ST_RR: begin
				op_a = zr_q;
				op_b = zr_q;
			end
			ST_II: begin
				op_a = zi_q;
				op_b = zi_q;
			end
			default: begin
				op_a = zr_q;
				op_b = zi_q;
			end
		endcase
	end

	// in ST_RI prod_q holds zi^2; in ST_UPD it holds zr*zi
	assign sum_sq = SW'(rr_q) + SW'(prod_q);
	assign diff   = SW'(rr_q) - SW'(prod_q);
	assign esc_sq = sum_sq > mep_pkg::ESC_SQ_LIMIT;
	assign n_inc  = n_q + 1'b1;

	// floor shifts; the values stay far inside the signed 66-bit range
	assign nr = (NW'(diff_q) >>> F) + NW'(cr_q);
	assign ni = (NW'(prod_q) >>> (F - 1)) + NW'(ci_q);
	assign esc_mag = (nr > mep_pkg::ESC_MAG_LIMIT) || (nr < -mep_pkg::ESC_MAG_LIMIT) ||
		(ni > mep_pkg::ESC_MAG_LIMIT) || (ni < -mep_pkg::ESC_MAG_LIMIT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (limit == '0) ? ST_DONE : ST_RR;
				end
			end
			ST_RR:   state_d = ST_II;
			ST_II:   state_d = ST_RI;
			ST_RI: begin
				if (first_q) begin
					state_d = ST_UPD;
				end else if (esc_sq || n_inc == limit) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_UPD;
				end
			end
			ST_UPD:  state_d = esc_mag ? ST_DONE : ST_RR;
			ST_DONE: begin
				if (ack) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					zr_q     <= ZW'(c_re);
					zi_q     <= ZW'(c_im);
					cr_q     <= c_re;
					ci_q     <= c_im;
					n_q      <= '0;
					first_q  <= 1'b1;
					inside_q <= (limit == '0);
				end
			end
			ST_II: rr_q <= prod_q;
			ST_RI: begin
				diff_q <= diff;
				// the starting point itself is never tested
				if (first_q) begin
					first_q <= 1'b0;
				end else if (!esc_sq) begin
					n_q      <= n_inc;
					inside_q <= (n_inc == limit);
				end
			end
			ST_UPD: begin
				if (!esc_mag) begin
					zr_q <= ZW'(nr);
					zi_q <= ZW'(ni);
				end
			end
			default: ;
		endcase
	end

	assign idle       = (state_q == ST_IDLE);
	assign res.done   = (state_q == ST_DONE);
	assign res.count  = n_q;
	assign res.in_set = inside_q;

endmodule

>>> design/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel: top level with config register and result stage.
// Depends on mep_pkg, mep_ifs, mep_iter, mep_shade.
`timescale 1ns / 1ps

// One point c (signed Q4.28) is taken per transfer on pt; one result comes
// out on res: the count of z = z*z + c steps (z starting at c) that stay
// within |z|^2 <= 4, an inside flag when the count reaches the limit, and a
// colour (black inside, else blue = 64 + n/2, green = n/2, red = n, mod 256).
// The limit is max_iter from cfg_wdata, capped at 256; write it only while
// no point is in flight. A limit of zero reports every point inside with a
// count of 0. Every step runs on the one shared 32x32 multiplier in turn:
// zr^2, zi^2, zr*zi, then the update. A point ends when its z leaves the
// +-2.0 box at an update, when the |z|^2 test catches it, or when its count
// reaches the limit. pt.ready is high only while the sequencer is free; a
// finished result sits in the output register, so the next point can start
// while it waits to be taken.

module mandelbrot_escape_pixel (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mep_pkg::CNT_W-1:0]   cfg_wdata,
	mep_pt_if.sink                      pt,
	mep_res_if.source                   res
);

	logic [mep_pkg::CNT_W-1:0] max_iter_q;
	logic [mep_pkg::CNT_W-1:0] limit;
	logic                      iter_idle;
	logic                      start;
	logic                      ack;
	logic                      res_valid_q;
	mep_pkg::iter_res_t        iter_res;
	mep_pkg::shade_t           shade;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= mep_pkg::MAX_ITER_RESET;
		end else if (cfg_we) begin
			max_iter_q <= cfg_wdata;
		end
	end

	assign limit = (max_iter_q > mep_pkg::ITER_CAP) ? mep_pkg::ITER_CAP : max_iter_q;

	assign pt.ready = iter_idle;
	assign start    = pt.valid && iter_idle;

	mep_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.c_re   (pt.c_re),
		.c_im   (pt.c_im),
		.limit  (limit),
		.ack    (ack),
		.idle   (iter_idle),
		.res    (iter_res)
	);

	mep_shade u_shade (
		.res   (iter_res),
		.shade (shade)
	);

	// hand over when the output stage is empty or drains this cycle
	assign ack = iter_res.done && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ack) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			res.iter_count <= iter_res.count;
			res.inside_res <= iter_res.in_set;
			res.blue       <= shade.blue;
			res.green      <= shade.green;
			res.red        <= shade.red;
		end
	end

	assign res.valid = res_valid_q;

endmodule

>>> design/mep_checker.sv
// Port-level checks of the escape-time pixel, bound to the top level.
// Depends on mep_pkg and mandelbrot_escape_pixel_macros.svh.
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_macros.svh"

module mep_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pt_valid,
	input logic                          pt_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [mep_pkg::CNT_W-1:0]     res_iter_count,
	input logic                          res_inside,
	input logic [mep_pkg::COLOR_W-1:0]   res_blue,
	input logic [mep_pkg::COLOR_W-1:0]   res_green,
	input logic [mep_pkg::COLOR_W-1:0]   res_red
);

	localparam int CW = mep_pkg::COLOR_W;

	// a point takes the sequencer, so no second transfer follows at once
	`MEP_ASSERT_NEXT(a_busy_after_pt, pt_valid && pt_ready, !pt_ready)

	// a fresh result only comes from a sequencer that was busy
	`MEP_ASSERT_SAME(a_res_from_busy, $rose(res_valid), $past(!pt_ready))

	// blue and red follow the count for points that escaped
	`MEP_ASSERT_SAME(a_shade_ramp, res_valid && !res_inside,
		res_blue == CW'(mep_pkg::BLUE_BASE + CW'(res_iter_count >> 1)) &&
		res_red == CW'(res_iter_count))

	// a stalled result holds
	`MEP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable(res_iter_count) && $stable(res_inside) &&
		$stable(res_blue) && $stable(res_green) && $stable(res_red))

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pt_valid       (pt.valid),
	.pt_ready       (pt.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_iter_count (res.iter_count),
	.res_inside     (res.inside_res),
	.res_blue       (res.blue),
	.res_green      (res.green),
	.res_red        (res.red)
);
